### hdl/u16550_pkg.sv
package u16550_pkg;

    // Default queue depth of both FIFOs
    localparam int U16550_FIFO_DEPTH = 16;

    localparam int BYTE_W = 8;

    // Kind of an input word
    typedef enum logic [1:0] {
        REQ_READ    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_LINE_RX = 2'd2,
        REQ_LINE_TX = 2'd3
    } u16550_req_t;

    // Register offsets
    localparam logic [2:0] OFF_RBR = 3'd0;   // RBR / THR / DLL
    localparam logic [2:0] OFF_IER = 3'd1;   // IER / DLM
    localparam logic [2:0] OFF_IIR = 3'd2;   // IIR read, FCR write
    localparam logic [2:0] OFF_LCR = 3'd3;
    localparam logic [2:0] OFF_MCR = 3'd4;
    localparam logic [2:0] OFF_LSR = 3'd5;
    localparam logic [2:0] OFF_MSR = 3'd6;
    localparam logic [2:0] OFF_SCR = 3'd7;

    // Bit positions
    localparam int LCR_DLAB_IDX  = 7;
    localparam int MCR_DTR_IDX   = 0;
    localparam int MCR_RTS_IDX   = 1;
    localparam int MCR_OUT2_IDX  = 3;
    localparam int MCR_LOOP_IDX  = 4;
    localparam int IER_RX_IDX    = 0;
    localparam int IER_THRE_IDX  = 1;
    localparam int IER_LS_IDX    = 2;
    localparam int FCR_EN_IDX    = 0;
    localparam int FCR_RXCLR_IDX = 1;
    localparam int FCR_TXCLR_IDX = 2;

    // IIR and LSR read values
    localparam logic [7:0] IIR_FIFO_BITS = 8'hC0;
    localparam logic [7:0] IIR_LS        = 8'h06;
    localparam logic [7:0] IIR_RX        = 8'h04;
    localparam logic [7:0] IIR_THRE      = 8'h02;
    localparam logic [7:0] IIR_NONE      = 8'h01;
    localparam logic [7:0] LSR_DR        = 8'h01;
    localparam logic [7:0] LSR_OE        = 8'h02;
    localparam logic [7:0] LSR_TEMT      = 8'h60;

    // What the output stage needs to finish one word
    typedef struct packed {
        logic             rd_mem;    // read data comes from the receive memory
        logic [BYTE_W-1:0] rd_imm;   // read data otherwise
        logic             tx_valid;  // transmit byte comes from the transmit memory
    } u16550_issue_t;

    // Interrupt and modem pins as left by the last word
    typedef struct packed {
        logic irq;
        logic dtr;
        logic rts;
        logic out2;
    } u16550_pins_t;

endpackage

### hdl/uart_16550_register_block_top.sv
// Register side of a 16550 UART, driven one word at a time. Each input word is
// a bus read or write at offsets 0 to 7 (tuser selects the kind), a byte arriving
// from the serial line, or the line taking the next transmit byte. Every word gives
// exactly one output word: read data, the transmit byte when one goes to the line,
// and the interrupt request and DTR/RTS/OUT2 pins as left by that word. The block
// takes one word per clock for as long as the output side keeps up. Accepting a
// word updates the registers and starts the read of the receive or transmit FIFO
// memory; the word then waits in the middle stage until the output register is
// free and is loaded into it. Both FIFOs live in single-write, single-read
// synchronous memories of FIFO_DEPTH bytes; entries are tracked by fill count and
// read position, so no clearing pass runs after reset and words are taken at once.
// Baud timing, character timeout and modem status are not implemented (MSR reads 0).
module uart_16550_register_block_top
    import u16550_pkg::*;
#(
    parameter int FIFO_DEPTH = U16550_FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // reg_offset[2:0], write_data[10:3], line_byte[18:11]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // read_data[7:0], tx_valid[8], tx_byte[16:9],
                                        // irq[17], dtr_out[18], rts_out[19], out2_out[20]
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic              accept;
    logic              p_adv;
    logic              p_valid_reg;
    u16550_issue_t     p_issue_reg;
    u16550_issue_t     issue;
    u16550_pins_t      pins;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_read_data_reg;
    logic              out_tx_valid_reg;
    logic [BYTE_W-1:0] out_tx_byte_reg;
    u16550_pins_t      out_pins_reg;

    logic              rx_rd_en, rx_wr_en, tx_rd_en, tx_wr_en;
    logic [PTR_W-1:0]  rx_rd_addr, rx_wr_addr, tx_rd_addr, tx_wr_addr;
    logic [BYTE_W-1:0] rx_wr_data, tx_wr_data, rx_rdata, tx_rdata;

    // The middle stage moves on when the output register is free or being emptied
    assign p_adv         = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !p_valid_reg || p_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    u16550_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req        (u16550_req_t'(s_axis_tuser[1:0])),
        .offset     (s_axis_tdata[2:0]),
        .wdata      (s_axis_tdata[10:3]),
        .line_byte  (s_axis_tdata[18:11]),
        .tx_rdata   (tx_rdata),
        .issue      (issue),
        .pins       (pins),
        .rx_rd_en   (rx_rd_en),
        .rx_rd_addr (rx_rd_addr),
        .rx_wr_en   (rx_wr_en),
        .rx_wr_addr (rx_wr_addr),
        .rx_wr_data (rx_wr_data),
        .tx_rd_en   (tx_rd_en),
        .tx_rd_addr (tx_rd_addr),
        .tx_wr_en   (tx_wr_en),
        .tx_wr_addr (tx_wr_addr),
        .tx_wr_data (tx_wr_data)
    );

    // Receive FIFO storage
    u16550_ram #(
        .DEPTH (FIFO_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_wr_en),
        .waddr (rx_wr_addr),
        .wdata (rx_wr_data),
        .re    (rx_rd_en),
        .raddr (rx_rd_addr),
        .rdata (rx_rdata)
    );

    // Transmit FIFO storage
    u16550_ram #(
        .DEPTH (FIFO_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_wr_en),
        .waddr (tx_wr_addr),
        .wdata (tx_wr_data),
        .re    (tx_rd_en),
        .raddr (tx_rd_addr),
        .rdata (tx_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_adv)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_adv)
            begin
                out_valid_reg <= p_valid_reg;
            end
        end
    end

    // Memory read data is held until the next accepted word, so finish the word here.
    // The pins reflect the state this word left: the next word updates it on this edge.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_issue_reg <= issue;
        end
        if (p_adv && p_valid_reg)
        begin
            out_read_data_reg <= p_issue_reg.rd_mem ? rx_rdata : p_issue_reg.rd_imm;
            out_tx_valid_reg  <= p_issue_reg.tx_valid;
            out_tx_byte_reg   <= p_issue_reg.tx_valid ? tx_rdata : '0;
            out_pins_reg      <= pins;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000,
                            out_pins_reg.out2,
                            out_pins_reg.rts,
                            out_pins_reg.dtr,
                            out_pins_reg.irq,
                            out_tx_byte_reg,
                            out_tx_valid_reg,
                            out_read_data_reg};

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> p_valid_reg && m_axis_tvalid)
        else $error("input held off with a free stage");

    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg && !p_adv |=> p_valid_reg)
        else $error("stalled word dropped from middle stage");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> p_valid_reg)
        else $error("accepted word not in middle stage");

endmodule

### hdl/u16550_ram.sv
module u16550_ram
    import u16550_pkg::*;
#(
    parameter int  DEPTH  = U16550_FIFO_DEPTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];

    // Write first: a read of the entry being written returns the new byte
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

endmodule

### hdl/u16550_ctrl.sv
module u16550_ctrl
    import u16550_pkg::*;
#(
    parameter int  FIFO_DEPTH = U16550_FIFO_DEPTH,
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  u16550_req_t       req,
    input  logic [2:0]        offset,
    input  logic [BYTE_W-1:0] wdata,
    input  logic [BYTE_W-1:0] line_byte,
    input  logic [BYTE_W-1:0] tx_rdata,
    output u16550_issue_t     issue,
    output u16550_pins_t      pins,
    output logic              rx_rd_en,
    output logic [PTR_W-1:0]  rx_rd_addr,
    output logic              rx_wr_en,
    output logic [PTR_W-1:0]  rx_wr_addr,
    output logic [BYTE_W-1:0] rx_wr_data,
    output logic              tx_rd_en,
    output logic [PTR_W-1:0]  tx_rd_addr,
    output logic              tx_wr_en,
    output logic [PTR_W-1:0]  tx_wr_addr,
    output logic [BYTE_W-1:0] tx_wr_data
);

    localparam int SUM_W = LVL_W + 1;
    localparam int T4    = (FIFO_DEPTH < 4)  ? FIFO_DEPTH : 4;
    localparam int T8    = (FIFO_DEPTH < 8)  ? FIFO_DEPTH : 8;
    localparam int T14   = (FIFO_DEPTH < 14) ? FIFO_DEPTH : 14;

    logic [LVL_W-1:0]  rx_level_reg, rx_level_next;
    logic [PTR_W-1:0]  rx_rpos_reg, rx_rpos_next;
    logic [LVL_W-1:0]  tx_level_reg, tx_level_next;
    logic [PTR_W-1:0]  tx_rpos_reg, tx_rpos_next;
    logic [3:0]        ier_reg, ier_next;
    logic [7:0]        lcr_reg, lcr_next;
    logic [4:0]        mcr_reg, mcr_next;
    logic [15:0]       div_reg, div_next;
    logic [7:0]        scr_reg, scr_next;
    logic              fifo_en_reg, fifo_en_next;
    logic [1:0]        trig_sel_reg, trig_sel_next;
    logic              ovr_reg, ovr_next;
    logic              thre_reg, thre_next;

    // Receive write held back to the next cycle: loopback data comes out of the tx memory
    logic              wrp_valid_reg, wrp_valid_next;
    logic [PTR_W-1:0]  wrp_addr_reg, wrp_addr_next;
    logic [BYTE_W-1:0] wrp_data_reg, wrp_data_next;
    logic              wrp_from_tx_reg, wrp_from_tx_next;

    logic              dlab, loop;
    logic [LVL_W-1:0]  cap, trig;
    logic              ls_src, rx_src, th_src;
    logic [7:0]        fifo_bits;
    logic [SUM_W-1:0]  rx_sum, tx_sum;
    logic [PTR_W-1:0]  rx_wpos, tx_wpos, rx_rpos_inc, tx_rpos_inc;
    logic              push_req, push_from_tx;
    logic [BYTE_W-1:0] push_data;

    assign dlab = lcr_reg[LCR_DLAB_IDX];
    assign loop = mcr_reg[MCR_LOOP_IDX];
    assign cap  = fifo_en_reg ? LVL_W'(FIFO_DEPTH) : LVL_W'(1);

    always_comb
    begin
        trig = LVL_W'(1);
        if (fifo_en_reg)
        begin
            unique case (trig_sel_reg)
                2'd0: trig = LVL_W'(1);
                2'd1: trig = LVL_W'(T4);
                2'd2: trig = LVL_W'(T8);
                2'd3: trig = LVL_W'(T14);
            endcase
        end
    end

    assign ls_src    = ier_reg[IER_LS_IDX] && ovr_reg;
    assign rx_src    = ier_reg[IER_RX_IDX] && (rx_level_reg != '0) && (rx_level_reg >= trig);
    assign th_src    = ier_reg[IER_THRE_IDX] && thre_reg;
    assign fifo_bits = fifo_en_reg ? IIR_FIFO_BITS : 8'h00;

    // Write position: read position plus fill, wrapped once
    assign rx_sum  = SUM_W'(rx_rpos_reg) + SUM_W'(rx_level_reg);
    assign tx_sum  = SUM_W'(tx_rpos_reg) + SUM_W'(tx_level_reg);
    assign rx_wpos = (rx_sum >= SUM_W'(FIFO_DEPTH)) ? PTR_W'(rx_sum - SUM_W'(FIFO_DEPTH))
                                                    : PTR_W'(rx_sum);
    assign tx_wpos = (tx_sum >= SUM_W'(FIFO_DEPTH)) ? PTR_W'(tx_sum - SUM_W'(FIFO_DEPTH))
                                                    : PTR_W'(tx_sum);
    assign rx_rpos_inc = (rx_rpos_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rx_rpos_reg + 1'b1;
    assign tx_rpos_inc = (tx_rpos_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tx_rpos_reg + 1'b1;

    always_comb
    begin
        rx_level_next    = rx_level_reg;
        rx_rpos_next     = rx_rpos_reg;
        tx_level_next    = tx_level_reg;
        tx_rpos_next     = tx_rpos_reg;
        ier_next         = ier_reg;
        lcr_next         = lcr_reg;
        mcr_next         = mcr_reg;
        div_next         = div_reg;
        scr_next         = scr_reg;
        fifo_en_next     = fifo_en_reg;
        trig_sel_next    = trig_sel_reg;
        ovr_next         = ovr_reg;
        thre_next        = thre_reg;
        issue            = '0;
        rx_rd_en         = 1'b0;
        tx_rd_en         = 1'b0;
        tx_wr_en         = 1'b0;
        push_req         = 1'b0;
        push_data        = wdata;
        push_from_tx     = 1'b0;
        wrp_valid_next   = 1'b0;
        wrp_addr_next    = rx_wpos;
        wrp_data_next    = wdata;
        wrp_from_tx_next = 1'b0;

        if (accept)
        begin
            unique case (req)
                REQ_READ:
                begin
                    unique case (offset)
                        OFF_RBR:
                        begin
                            if (dlab)
                            begin
                                issue.rd_imm = div_reg[7:0];
                            end
                            else if (rx_level_reg != '0)
                            begin
                                issue.rd_mem  = 1'b1;
                                rx_rd_en      = 1'b1;
                                rx_rpos_next  = rx_rpos_inc;
                                rx_level_next = rx_level_reg - 1'b1;
                            end
                        end
                        OFF_IER:
                        begin
                            issue.rd_imm = dlab ? div_reg[15:8] : {4'b0000, ier_reg};
                        end
                        OFF_IIR:
                        begin
                            priority if (ls_src)
                            begin
                                issue.rd_imm = fifo_bits | IIR_LS;
                            end
                            else if (rx_src)
                            begin
                                issue.rd_imm = fifo_bits | IIR_RX;
                            end
                            else if (th_src)
                            begin
                                issue.rd_imm = fifo_bits | IIR_THRE;
                                thre_next    = 1'b0;
                            end
                            else
                            begin
                                issue.rd_imm = fifo_bits | IIR_NONE;
                            end
                        end
                        OFF_LCR: issue.rd_imm = lcr_reg;
                        OFF_MCR: issue.rd_imm = {3'b000, mcr_reg};
                        OFF_LSR:
                        begin
                            issue.rd_imm = ((rx_level_reg != '0) ? LSR_DR : 8'h00)
                                         | (ovr_reg ? LSR_OE : 8'h00)
                                         | ((tx_level_reg == '0) ? LSR_TEMT : 8'h00);
                            ovr_next     = 1'b0;
                        end
                        OFF_MSR: issue.rd_imm = 8'h00;
                        OFF_SCR: issue.rd_imm = scr_reg;
                    endcase
                end
                REQ_WRITE:
                begin
                    unique case (offset)
                        OFF_RBR:
                        begin
                            if (dlab)
                            begin
                                div_next[7:0] = wdata;
                            end
                            else if (loop)
                            begin
                                push_req  = 1'b1;
                                push_data = wdata;
                                thre_next = 1'b1;
                            end
                            else
                            begin
                                if (tx_level_reg < cap)
                                begin
                                    tx_wr_en      = 1'b1;
                                    tx_level_next = tx_level_reg + 1'b1;
                                end
                                thre_next = 1'b0;
                            end
                        end
                        OFF_IER:
                        begin
                            if (dlab)
                            begin
                                div_next[15:8] = wdata;
                            end
                            else
                            begin
                                if (wdata[IER_THRE_IDX] && !ier_reg[IER_THRE_IDX]
                                    && (tx_level_reg == '0))
                                begin
                                    thre_next = 1'b1;
                                end
                                ier_next = wdata[3:0];
                            end
                        end
                        OFF_IIR:
                        begin
                            // Changing the enable empties both queues
                            if (wdata[FCR_EN_IDX] != fifo_en_reg)
                            begin
                                rx_level_next = '0;
                                rx_rpos_next  = '0;
                                if (tx_level_reg != '0)
                                begin
                                    thre_next = 1'b1;
                                end
                                tx_level_next = '0;
                                tx_rpos_next  = '0;
                            end
                            if (wdata[FCR_EN_IDX] && wdata[FCR_RXCLR_IDX])
                            begin
                                rx_level_next = '0;
                                rx_rpos_next  = '0;
                            end
                            if (wdata[FCR_EN_IDX] && wdata[FCR_TXCLR_IDX])
                            begin
                                tx_level_next = '0;
                                tx_rpos_next  = '0;
                                thre_next     = 1'b1;
                            end
                            fifo_en_next  = wdata[FCR_EN_IDX];
                            trig_sel_next = wdata[7:6];
                        end
                        OFF_LCR: lcr_next = wdata;
                        OFF_MCR: mcr_next = wdata[4:0];
                        OFF_LSR:
                        begin
                        end
                        OFF_MSR:
                        begin
                        end
                        OFF_SCR: scr_next = wdata;
                    endcase
                end
                REQ_LINE_RX:
                begin
                    if (!loop)
                    begin
                        push_req  = 1'b1;
                        push_data = line_byte;
                    end
                end
                REQ_LINE_TX:
                begin
                    if (tx_level_reg != '0)
                    begin
                        tx_rd_en      = 1'b1;
                        tx_rpos_next  = tx_rpos_inc;
                        tx_level_next = tx_level_reg - 1'b1;
                        if (tx_level_reg == LVL_W'(1))
                        begin
                            thre_next = 1'b1;
                        end
                        if (loop)
                        begin
                            push_req     = 1'b1;
                            push_from_tx = 1'b1;
                        end
                        else
                        begin
                            issue.tx_valid = 1'b1;
                        end
                    end
                end
            endcase
        end

        // Receive push: append, or overrun (overwrite the held byte when FIFOs are off)
        if (push_req)
        begin
            wrp_data_next    = push_data;
            wrp_from_tx_next = push_from_tx;
            if (rx_level_reg < cap)
            begin
                wrp_valid_next = 1'b1;
                wrp_addr_next  = rx_wpos;
                rx_level_next  = rx_level_reg + 1'b1;
            end
            else
            begin
                ovr_next = 1'b1;
                if (!fifo_en_reg)
                begin
                    wrp_valid_next = 1'b1;
                    wrp_addr_next  = rx_rpos_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_level_reg  <= '0;
            rx_rpos_reg   <= '0;
            tx_level_reg  <= '0;
            tx_rpos_reg   <= '0;
            ier_reg       <= '0;
            lcr_reg       <= '0;
            mcr_reg       <= '0;
            div_reg       <= '0;
            scr_reg       <= '0;
            fifo_en_reg   <= 1'b0;
            trig_sel_reg  <= '0;
            ovr_reg       <= 1'b0;
            thre_reg      <= 1'b0;
            wrp_valid_reg <= 1'b0;
        end
        else
        begin
            rx_level_reg  <= rx_level_next;
            rx_rpos_reg   <= rx_rpos_next;
            tx_level_reg  <= tx_level_next;
            tx_rpos_reg   <= tx_rpos_next;
            ier_reg       <= ier_next;
            lcr_reg       <= lcr_next;
            mcr_reg       <= mcr_next;
            div_reg       <= div_next;
            scr_reg       <= scr_next;
            fifo_en_reg   <= fifo_en_next;
            trig_sel_reg  <= trig_sel_next;
            ovr_reg       <= ovr_next;
            thre_reg      <= thre_next;
            wrp_valid_reg <= wrp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wrp_addr_reg    <= wrp_addr_next;
        wrp_data_reg    <= wrp_data_next;
        wrp_from_tx_reg <= wrp_from_tx_next;
    end

    assign rx_rd_addr = rx_rpos_reg;
    assign rx_wr_en   = wrp_valid_reg;
    assign rx_wr_addr = wrp_addr_reg;
    assign rx_wr_data = wrp_from_tx_reg ? tx_rdata : wrp_data_reg;
    assign tx_rd_addr = tx_rpos_reg;
    assign tx_wr_addr = tx_wpos;
    assign tx_wr_data = wdata;

    assign pins.irq  = ls_src || rx_src || th_src;
    assign pins.dtr  = !loop && mcr_reg[MCR_DTR_IDX];
    assign pins.rts  = !loop && mcr_reg[MCR_RTS_IDX];
    assign pins.out2 = !loop && mcr_reg[MCR_OUT2_IDX];

    a_rx_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rx_level_reg <= cap)
        else $error("receive fill above capacity");

    a_tx_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
        tx_level_reg <= cap)
        else $error("transmit fill above capacity");

    a_lsr_clears_ovr: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req == REQ_READ) && (offset == OFF_LSR) |=> !ovr_reg)
        else $error("overrun survived an LSR read");

    a_thr_clears_thre: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req == REQ_WRITE) && (offset == OFF_RBR) && !dlab && !loop
        |=> !thre_reg)
        else $error("THR empty pending after a THR write");

endmodule

### dv/uart_16550_register_block_check.sv
`timescale 1ns / 100ps

module uart_16550_register_block_check
    import u16550_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // reg_offset[2:0], write_data[10:3], line_byte[18:11]
    input  logic [1:0]  s_axis_tuser,    // req_type[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,    // read_data[7:0], tx_valid[8], tx_byte[16:9],
                                         // irq[17], dtr_out[18], rts_out[19], out2_out[20]
    output int          words_pending,
    output int          words_checked,
    output int          tx_handed,
    output int          irq_raised,
    output int          fail_count
);

    localparam int DEPTH = U16550_FIFO_DEPTH;

    typedef struct packed {
        logic       out2;
        logic       rts;
        logic       dtr;
        logic       irq;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [7:0] read_data;
    } uart_word_t;

    // Shadow of the UART registers and both queues
    logic [7:0]  rx_mem [DEPTH];
    logic [7:0]  tx_mem [DEPTH];
    int          rx_fill, rx_head, tx_fill, tx_head;
    logic [3:0]  ier;
    logic [7:0]  lcr;
    logic [4:0]  mcr;
    logic [15:0] divisor;
    logic [7:0]  scratch;
    logic        fifo_on;
    logic [1:0]  trig_sel;
    logic        overrun, thre_pend;

    uart_word_t  expected_words [$];

    function automatic void clear_shadow();
        for (int i = 0; i < DEPTH; i++)
        begin
            rx_mem[i] = '0;
            tx_mem[i] = '0;
        end
        rx_fill = 0;
        rx_head = 0;
        tx_fill = 0;
        tx_head = 0;
        ier = '0;
        lcr = '0;
        mcr = '0;
        divisor = '0;
        scratch = '0;
        fifo_on = 1'b0;
        trig_sel = '0;
        overrun = 1'b0;
        thre_pend = 1'b0;
    endfunction

    function automatic int queue_cap();
        return fifo_on ? DEPTH : 1;
    endfunction

    function automatic int rx_trigger_level();
        int lvl;
        lvl = 1;
        if (fifo_on)
        begin
            case (trig_sel)
                2'd0:    lvl = 1;
                2'd1:    lvl = 4;
                2'd2:    lvl = 8;
                default: lvl = 14;
            endcase
        end
        if (lvl > queue_cap())
            lvl = queue_cap();
        return lvl;
    endfunction

    function automatic void rx_enqueue(logic [7:0] b);
        if (rx_fill < queue_cap())
        begin
            rx_mem[(rx_head + rx_fill) % DEPTH] = b;
            rx_fill++;
        end
        else
        begin
            overrun = 1'b1;
            // single-byte mode: newest byte replaces the held one
            if (!fifo_on)
                rx_mem[rx_head] = b;
        end
    endfunction

    function automatic logic ls_int();
        return ier[IER_LS_IDX] && overrun;
    endfunction

    function automatic logic rx_int();
        return ier[IER_RX_IDX] && rx_fill >= rx_trigger_level() && rx_fill > 0;
    endfunction

    function automatic logic thre_int();
        return ier[IER_THRE_IDX] && thre_pend;
    endfunction

    function automatic logic [7:0] register_read(logic [2:0] off);
        logic [7:0] v;
        logic [7:0] fifo_bits;
        v = '0;
        fifo_bits = fifo_on ? IIR_FIFO_BITS : 8'h00;
        case (off)
            OFF_RBR:
            begin
                if (lcr[LCR_DLAB_IDX])
                    v = divisor[7:0];
                else if (rx_fill > 0)
                begin
                    v = rx_mem[rx_head];
                    rx_head = (rx_head + 1) % DEPTH;
                    rx_fill--;
                end
            end
            OFF_IER:
                v = lcr[LCR_DLAB_IDX] ? divisor[15:8] : {4'h0, ier};
            OFF_IIR:
            begin
                if (ls_int())
                    v = fifo_bits | IIR_LS;
                else if (rx_int())
                    v = fifo_bits | IIR_RX;
                else if (thre_int())
                begin
                    thre_pend = 1'b0;
                    v = fifo_bits | IIR_THRE;
                end
                else
                    v = fifo_bits | IIR_NONE;
            end
            OFF_LCR: v = lcr;
            OFF_MCR: v = {3'b000, mcr};
            OFF_LSR:
            begin
                v = (rx_fill > 0 ? LSR_DR : 8'h00) | (overrun ? LSR_OE : 8'h00)
                    | (tx_fill == 0 ? LSR_TEMT : 8'h00);
                overrun = 1'b0;
            end
            OFF_SCR: v = scratch;
            default: v = '0;    // modem status reads as zero
        endcase
        return v;
    endfunction

    function automatic void register_write(logic [2:0] off, logic [7:0] d);
        case (off)
            OFF_RBR:
            begin
                if (lcr[LCR_DLAB_IDX])
                    divisor[7:0] = d;
                else if (mcr[MCR_LOOP_IDX])
                begin
                    rx_enqueue(d);
                    thre_pend = 1'b1;
                end
                else
                begin
                    if (tx_fill < queue_cap())
                    begin
                        tx_mem[(tx_head + tx_fill) % DEPTH] = d;
                        tx_fill++;
                    end
                    thre_pend = 1'b0;
                end
            end
            OFF_IER:
            begin
                if (lcr[LCR_DLAB_IDX])
                    divisor[15:8] = d;
                else
                begin
                    if (d[IER_THRE_IDX] && !ier[IER_THRE_IDX] && tx_fill == 0)
                        thre_pend = 1'b1;
                    ier = d[3:0];
                end
            end
            OFF_IIR:
            begin
                // toggling the enable flushes both queues
                if (d[FCR_EN_IDX] != fifo_on)
                begin
                    rx_fill = 0;
                    rx_head = 0;
                    if (tx_fill != 0)
                        thre_pend = 1'b1;
                    tx_fill = 0;
                    tx_head = 0;
                end
                if (d[FCR_EN_IDX] && d[FCR_RXCLR_IDX])
                begin
                    rx_fill = 0;
                    rx_head = 0;
                end
                if (d[FCR_EN_IDX] && d[FCR_TXCLR_IDX])
                begin
                    tx_fill = 0;
                    tx_head = 0;
                    thre_pend = 1'b1;
                end
                fifo_on = d[FCR_EN_IDX];
                trig_sel = d[7:6];
            end
            OFF_LCR: lcr = d;
            OFF_MCR: mcr = d[4:0];
            OFF_SCR: scratch = d;
            default: ;          // LSR and MSR take no writes
        endcase
    endfunction

    function automatic uart_word_t predict_word(u16550_req_t kind, logic [2:0] off,
                                                logic [7:0] wd, logic [7:0] lb);
        uart_word_t w;
        logic [7:0] b;
        logic       loop;
        w = '0;
        case (kind)
            REQ_READ:  w.read_data = register_read(off);
            REQ_WRITE: register_write(off, wd);
            REQ_LINE_RX:
            begin
                if (!mcr[MCR_LOOP_IDX])
                    rx_enqueue(lb);
            end
            default:
            begin
                if (tx_fill > 0)
                begin
                    b = tx_mem[tx_head];
                    tx_head = (tx_head + 1) % DEPTH;
                    tx_fill--;
                    if (tx_fill == 0)
                        thre_pend = 1'b1;
                    if (mcr[MCR_LOOP_IDX])
                        rx_enqueue(b);
                    else
                    begin
                        w.tx_valid = 1'b1;
                        w.tx_byte = b;
                    end
                end
            end
        endcase
        loop = mcr[MCR_LOOP_IDX];
        w.irq  = ls_int() || rx_int() || thre_int();
        w.dtr  = !loop && mcr[MCR_DTR_IDX];
        w.rts  = !loop && mcr[MCR_RTS_IDX];
        w.out2 = !loop && mcr[MCR_OUT2_IDX];
        return w;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        uart_word_t exp_w;
        uart_word_t act_w;
        if (!rst_n)
        begin
            clear_shadow();
            expected_words.delete();
            words_pending <= 0;
        end
        else
        begin
            // retire the output word before queuing a new one
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("output word 0x%06h with nothing expected", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    act_w = uart_word_t'(m_axis_tdata[20:0]);
                    compare_field("read_data", exp_w.read_data, act_w.read_data);
                    compare_field("tx_valid", exp_w.tx_valid, act_w.tx_valid);
                    compare_field("tx_byte", exp_w.tx_byte, act_w.tx_byte);
                    compare_field("irq", exp_w.irq, act_w.irq);
                    compare_field("dtr_out", exp_w.dtr, act_w.dtr);
                    compare_field("rts_out", exp_w.rts, act_w.rts);
                    compare_field("out2_out", exp_w.out2, act_w.out2);
                    compare_field("tdata pad", 8'h00, {5'b00000, m_axis_tdata[23:21]});
                    words_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                exp_w = predict_word(u16550_req_t'(s_axis_tuser), s_axis_tdata[2:0],
                                     s_axis_tdata[10:3], s_axis_tdata[18:11]);
                if (exp_w.tx_valid)
                    tx_handed++;
                if (exp_w.irq)
                    irq_raised++;
                expected_words.push_back(exp_w);
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

### dv/uart_16550_register_block_top_test.sv
`timescale 1ns / 100ps

module uart_16550_register_block_top_test;
    import u16550_pkg::*;

    localparam int ITEM_TARGET   = 1950;
    localparam int LONG_HOLD     = 300;     // cycles the output side is held off
    localparam int PRESS_WORDS   = 48;      // words offered while it is held off
    localparam int SETTLE_CYCLES = 8;       // latency through the block plus margin
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum int {
        SINK_FREE,
        SINK_RANDOM,
        SINK_PERIODIC
    } sink_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;        // reg_offset[2:0], write_data[10:3], line_byte[18:11]
    logic [1:0]  s_axis_tuser = REQ_READ;  // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;             // read_data[7:0], tx_valid[8], tx_byte[16:9],
                                           // irq[17], dtr_out[18], rts_out[19], out2_out[20]

    int words_pending, words_checked, tx_handed, irq_raised, fail_count;
    int words_sent = 0;
    int burst_left = 0;
    bit gapless = 1'b0;
    bit valid_up = 1'b0;
    int hold_asks = 0;
    int hold_served = 0;
    int cycle_count = 0;

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    uart_16550_register_block_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    uart_16550_register_block_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .words_pending (words_pending),
        .words_checked (words_checked),
        .tx_handed     (tx_handed),
        .irq_raised    (irq_raised),
        .fail_count    (fail_count)
    );

    // Drop tvalid only if it is up, so each step sees at most one update of it
    task automatic drop_valid();
        if (valid_up)
        begin
            s_axis_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // Offer one word and hold it until the block takes it. Between bursts,
    // drop tvalid for a random gap; long bursts give stretches with no idling.
    task automatic put_item(input u16550_req_t kind, input logic [2:0] off,
                            input logic [7:0] wd, input logic [7:0] lb);
        if (burst_left == 0 && !gapless)
        begin
            drop_valid();
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'b00000, lb, wd, off};
        valid_up = 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        if (burst_left > 0)
            burst_left--;
        words_sent++;
    endtask

    task automatic bus_wr(input logic [2:0] off, input logic [7:0] d);
        put_item(REQ_WRITE, off, d, 8'($urandom));
    endtask

    task automatic bus_rd(input logic [2:0] off);
        put_item(REQ_READ, off, 8'($urandom), 8'($urandom));
    endtask

    task automatic line_rx(input logic [7:0] b);
        put_item(REQ_LINE_RX, 3'($urandom), 8'($urandom), b);
    endtask

    task automatic line_tx();
        put_item(REQ_LINE_TX, 3'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Pause the sender until every expected word has come back
    task automatic wait_drained();
        drop_valid();
        do @(posedge clk); while (words_pending != 0);
    endtask

    // One well-formed word of ordinary traffic; leaves LCR and MCR alone
    task automatic mixed_item();
        case ($urandom_range(0, 9))
            0, 1, 2: line_rx(8'($urandom));
            3, 4:    line_tx();
            5, 6:    bus_rd(3'($urandom));
            7:       bus_wr(OFF_RBR, 8'($urandom));
            8:       bus_rd(OFF_RBR);
            default: bus_wr(OFF_SCR, 8'($urandom));
        endcase
    endtask

    // Ask the receiver for a long hold-off and keep offering words back to back,
    // so the block fills and stalls its input
    task automatic press_output();
        hold_asks <= hold_asks + 1;
        gapless = 1'b1;
        repeat (PRESS_WORDS) mixed_item();
        gapless = 1'b0;
    endtask

    // New register settings: DLAB now and then, FIFOs mostly on, loopback rarely
    task automatic reconfigure();
        logic [7:0] d;
        if ($urandom_range(0, 4) == 0)
        begin
            d = 8'($urandom);
            d[LCR_DLAB_IDX] = 1'b1;
            bus_wr(OFF_LCR, d);
            bus_wr(OFF_RBR, 8'($urandom));
            bus_wr(OFF_IER, 8'($urandom));
            bus_rd(OFF_RBR);
            bus_rd(OFF_IER);
        end
        d = 8'($urandom);
        d[LCR_DLAB_IDX] = 1'b0;
        bus_wr(OFF_LCR, d);
        bus_wr(OFF_IER, 8'($urandom));
        d = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            d[FCR_EN_IDX] = 1'b1;
        bus_wr(OFF_IIR, d);
        d = 8'($urandom);
        d[MCR_LOOP_IDX] = ($urandom_range(0, 4) == 0);
        bus_wr(OFF_MCR, d);
    endtask

    // Line delivers a run of bytes (deep enough to reach every trigger and
    // overrun), then the driver drains the receive queue
    task automatic rx_burst();
        int n;
        n = $urandom_range(1, 20);
        repeat (n)
        begin
            line_rx(8'($urandom));
            if ($urandom_range(0, 5) == 0)
                bus_rd($urandom_range(0, 1) ? OFF_IIR : OFF_LSR);
        end
        repeat ($urandom_range(0, n + 3))
        begin
            bus_rd(OFF_RBR);
            if ($urandom_range(0, 5) == 0)
                bus_rd($urandom_range(0, 1) ? OFF_IIR : OFF_LSR);
        end
    endtask

    // Driver fills the transmit queue, the line then empties it
    task automatic tx_burst();
        int n;
        n = $urandom_range(1, 20);
        repeat (n)
        begin
            bus_wr(OFF_RBR, 8'($urandom));
            if ($urandom_range(0, 7) == 0)
                bus_rd(OFF_IIR);
        end
        repeat (n + $urandom_range(0, 2))
            line_tx();
        if ($urandom_range(0, 1) == 0)
            bus_rd(OFF_IIR);
    endtask

    task automatic run_random(input int until_words);
        int pick;
        while (words_sent < until_words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                wait_drained();
            else if (pick < 4)
                press_output();
            else if (pick < 22)
                reconfigure();
            else if (pick < 45)
                rx_burst();
            else if (pick < 65)
                tx_burst();
            else if (pick < 75)
            begin
                repeat ($urandom_range(1, 4)) bus_rd(3'($urandom));
                bus_wr(OFF_SCR, 8'($urandom));
            end
            else if (pick < 92)
                repeat ($urandom_range(4, 12)) mixed_item();
            else
            begin
                // noise: any kind, any offset, any data
                repeat ($urandom_range(1, 6))
                    put_item(u16550_req_t'($urandom_range(0, 3)), 3'($urandom),
                             8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic run_directed();
        bus_rd(OFF_IIR);            // nothing pending after reset
        bus_rd(OFF_LSR);            // transmitter empty only
        bus_rd(OFF_RBR);            // empty receive buffer reads zero
        bus_rd(OFF_MSR);            // modem status not modelled
        bus_wr(OFF_LSR, 8'hFF);     // ignored
        bus_wr(OFF_MSR, 8'hFF);     // ignored
        bus_wr(OFF_SCR, 8'hFF);
        bus_rd(OFF_SCR);
        bus_wr(OFF_LCR, 8'h80);     // divisor latch access
        bus_wr(OFF_RBR, 8'hFF);
        bus_wr(OFF_IER, 8'h00);
        bus_rd(OFF_RBR);
        bus_wr(OFF_LCR, 8'h03);
        bus_wr(OFF_IER, 8'h0F);     // THR-empty source armed on an empty queue
        bus_rd(OFF_IIR);            // reports and clears it
        line_tx();                  // nothing queued to send
        bus_wr(OFF_RBR, 8'h5A);
        bus_wr(OFF_RBR, 8'hA5);     // single-byte queue full: dropped
        line_rx(8'hFF);
        line_rx(8'h00);             // overwrites the held byte, overrun
        bus_rd(OFF_LSR);
        bus_wr(OFF_MCR, 8'h1B);     // loopback forces the pins low
        line_tx();                  // byte loops back into the receive side
        line_rx(8'h77);             // line input ignored in loopback
        bus_wr(OFF_RBR, 8'h81);     // THR write goes straight to receive
        bus_rd(OFF_RBR);
        bus_wr(OFF_MCR, 8'h0B);
        bus_wr(OFF_IIR, 8'hC7);     // FIFOs on, trigger 14, clear both
    endtask

    // Receiver: phases of free flow, random stalls and a fixed pattern,
    // with a long counted hold-off whenever the sender asks for one
    initial
    begin : sink
        int         phase_left;
        int         stall_pct;
        int         period;
        int         tick;
        int         hold_left;
        sink_mode_t mode;
        logic       ready;
        phase_left = 0;
        stall_pct = 0;
        period = 1;
        tick = 0;
        hold_left = 0;
        mode = SINK_FREE;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_served && hold_left == 0)
            begin
                hold_left = LONG_HOLD;
                hold_served++;
            end
            if (hold_left > 0)
            begin
                ready = 1'b0;
                hold_left--;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode = sink_mode_t'($urandom_range(0, 2));
                    stall_pct = $urandom_range(10, 80);
                    period = $urandom_range(2, 5);
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                tick++;
                case (mode)
                    SINK_FREE:   ready = 1'b1;
                    SINK_RANDOM: ready = ($urandom_range(1, 100) > stall_pct);
                    default:     ready = ((tick % period) == 0);
                endcase
            end
            m_axis_tready <= ready;
        end
    end

    // Watchdog: stop a run that hangs
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Cycle limit reached with %0d words still expected", words_pending);
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(ITEM_TARGET * 3 / 10);
        press_output();
        run_random(ITEM_TARGET * 6 / 10);
        wait_drained();
        press_output();
        run_random(ITEM_TARGET);
        wait_drained();
        // give any stray word time to appear
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d bus and line words across FIFO on/off, DLAB and loopback settings",
                 words_sent);
        $display("Compared %0d output words: %0d transmit bytes, %0d with irq, %0d hold-offs",
                 words_checked, tx_handed, irq_raised, hold_served);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
hdl/u16550_pkg.sv
hdl/u16550_ram.sv
hdl/u16550_ctrl.sv
hdl/uart_16550_register_block_top.sv
dv/uart_16550_register_block_check.sv
dv/uart_16550_register_block_top_test.sv
